// ===== src/reliable_inorder_reorder_buffer_assert.svh =====
// assertion macros for the in-order receive buffer
// expects clk and rst_n in the scope of the module that uses them
`ifndef RELIABLE_INORDER_REORDER_BUFFER_ASSERT_SVH
`define RELIABLE_INORDER_REORDER_BUFFER_ASSERT_SVH

// same-cycle implication
`define RIOB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RIOB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/riob_pkg.sv =====
// shared types and codes for the in-order receive buffer
// no dependencies
package riob_pkg;

    localparam int SEQ_W    = 32;
    localparam int HANDLE_W = 16;
    localparam int CMP_W    = SEQ_W + 1;

    typedef enum logic [1:0] {
        KIND_ACK     = 2'd0,
        KIND_DELIVER = 2'd1,
        KIND_DROP    = 2'd2
    } kind_t;

    typedef struct packed {
        logic [SEQ_W-1:0]    sequence_req;
        logic [HANDLE_W-1:0] payload_handle;
    } req_t;

    typedef struct packed {
        kind_t               kind;
        logic [SEQ_W-1:0]    out_sequence;
        logic [HANDLE_W-1:0] out_handle;
        logic                last;
    } res_t;

    typedef struct packed {
        logic [CMP_W-1:0] diff;
        logic             eq;
        logic             gt;
    } cmp_res_t;

endpackage

// ===== src/reliable_inorder_reorder_buffer.sv =====
// in-order receive buffer: ack registered out of the classify state; busy, so taking no
// request, through classify when only acked or stored, classify and drop when dropped, and
// classify and a check per delivered result otherwise; draining runs at one slot a cycle.
// results appear on strobe for one cycle each; the receiver cannot stall.
// asynchronous reset: sequencer idle, last delivered 0, all slots empty, no clearing pass.
// depends on riob_pkg, riob_cmp, riob_slot_store and the assertion header
`include "reliable_inorder_reorder_buffer_assert.svh"

module reliable_inorder_reorder_buffer #(
    parameter int WINDOW = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  riob_pkg::req_t req,
    output logic           strobe,
    output riob_pkg::res_t result
);

    localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam logic [riob_pkg::CMP_W-1:0] WIN_CMP = riob_pkg::CMP_W'(WINDOW);
    localparam logic [IDX_W:0]   WIN_IDX  = (IDX_W+1)'(WINDOW);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);

    typedef enum logic [3:0] {
        ST_IDLE     = 4'b0001,
        ST_CLASSIFY = 4'b0010,
        ST_CHECK    = 4'b0100,
        ST_DROP     = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [riob_pkg::SEQ_W-1:0]    seq_reg, seq_next;
    logic [riob_pkg::HANDLE_W-1:0] handle_reg, handle_next;
    logic [riob_pkg::SEQ_W-1:0]    last_reg, last_next;
    logic [IDX_W-1:0]              head_reg, head_next;
    logic [riob_pkg::SEQ_W-1:0]    pend_seq_reg, pend_seq_next;
    logic [riob_pkg::HANDLE_W-1:0] pend_handle_reg, pend_handle_next;
    riob_pkg::res_t                result_reg, result_next;
    logic                          strobe_reg, strobe_next;

    logic [riob_pkg::CMP_W-1:0]    next_seq;
    logic [riob_pkg::CMP_W-1:0]    cmp_a;
    riob_pkg::cmp_res_t            cmp_res;
    logic                          in_window;
    logic [IDX_W:0]                idx_sum;
    logic [IDX_W-1:0]              store_idx;
    logic [IDX_W-1:0]              head_inc;
    logic                          head_valid;
    logic [riob_pkg::SEQ_W-1:0]    rd_seq;
    logic [riob_pkg::HANDLE_W-1:0] rd_handle;
    logic                          match;
    logic                          wr_en;
    logic                          clr_en;

    // the one compare unit: request against expected, then slot against expected
    assign next_seq = {1'b0, last_reg} + riob_pkg::CMP_W'(1);
    assign cmp_a    = (state_reg == ST_CHECK) ? {1'b0, rd_seq} : {1'b0, seq_reg};

    riob_cmp u_cmp (
        .a   (cmp_a),
        .b   (next_seq),
        .res (cmp_res)
    );

    // slot of a sequence ahead of the expected one is head plus offset, wrapped once
    assign in_window = (cmp_res.diff < WIN_CMP);
    assign idx_sum   = {1'b0, head_reg} + {1'b0, cmp_res.diff[IDX_W-1:0]};
    assign store_idx = (idx_sum >= WIN_IDX) ? IDX_W'(idx_sum - WIN_IDX) : idx_sum[IDX_W-1:0];
    assign head_inc  = (head_reg == LAST_IDX) ? '0 : head_reg + IDX_W'(1);
    assign match     = head_valid && cmp_res.eq;

    assign wr_en  = (state_reg == ST_CLASSIFY) && cmp_res.gt && in_window;
    assign clr_en = (state_reg == ST_CHECK) && match;

    riob_slot_store #(
        .WINDOW (WINDOW),
        .IDX_W  (IDX_W)
    ) u_slots (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (wr_en),
        .wr_idx     (store_idx),
        .wr_seq     (seq_reg),
        .wr_handle  (handle_reg),
        .clr_en     (clr_en),
        .head       (head_reg),
        .rd_addr    (head_next),
        .head_valid (head_valid),
        .rd_seq     (rd_seq),
        .rd_handle  (rd_handle)
    );

    always_comb
    begin
        state_next       = state_reg;
        seq_next         = seq_reg;
        handle_next      = handle_reg;
        last_next        = last_reg;
        head_next        = head_reg;
        pend_seq_next    = pend_seq_reg;
        pend_handle_next = pend_handle_reg;
        result_next      = result_reg;
        strobe_next      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    seq_next    = req.sequence_req;
                    handle_next = req.payload_handle;
                    state_next  = ST_CLASSIFY;
                end
            end
            ST_CLASSIFY:
            begin
                strobe_next              = 1'b1;
                result_next.kind         = riob_pkg::KIND_ACK;
                result_next.out_sequence = seq_reg;
                result_next.out_handle   = '0;
                result_next.last         = 1'b1;
                if (cmp_res.eq)
                begin
                    // in order: commit now, emit once the next slot has been looked at
                    result_next.last = 1'b0;
                    pend_seq_next    = seq_reg;
                    pend_handle_next = handle_reg;
                    last_next        = seq_reg;
                    head_next        = head_inc;
                    state_next       = ST_CHECK;
                end
                else if (cmp_res.gt && !in_window)
                begin
                    result_next.last = 1'b0;
                    state_next       = ST_DROP;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CHECK:
            begin
                strobe_next              = 1'b1;
                result_next.kind         = riob_pkg::KIND_DELIVER;
                result_next.out_sequence = pend_seq_reg;
                result_next.out_handle   = pend_handle_reg;
                result_next.last         = !match;
                if (match)
                begin
                    pend_seq_next    = rd_seq;
                    pend_handle_next = rd_handle;
                    last_next        = rd_seq;
                    head_next        = head_inc;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DROP:
            begin
                strobe_next              = 1'b1;
                result_next.kind         = riob_pkg::KIND_DROP;
                result_next.out_sequence = seq_reg;
                result_next.out_handle   = '0;
                result_next.last         = 1'b1;
                state_next               = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            last_reg   <= '0;
            head_reg   <= IDX_W'(1);
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            last_reg   <= last_next;
            head_reg   <= head_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seq_reg         <= seq_next;
        handle_reg      <= handle_next;
        pend_seq_reg    <= pend_seq_next;
        pend_handle_reg <= pend_handle_next;
        result_reg      <= result_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign strobe = strobe_reg;
    assign result = result_reg;

    `RIOB_ASSERT_NOW(a_drop_is_last,
        strobe && (result.kind == riob_pkg::KIND_DROP),
        result.last, "drop not marked last")
    `RIOB_ASSERT_NOW(a_handle_zero,
        strobe && (result.kind != riob_pkg::KIND_DELIVER),
        result.out_handle == '0, "non-delivery carries a handle")
    `RIOB_ASSERT_NEXT(a_ack_first, start && !busy,
        ##1 (strobe && (result.kind == riob_pkg::KIND_ACK)),
        "first result of a request is not an ack")
    `RIOB_ASSERT_NEXT(a_last_monotonic, 1'b1, last_reg >= $past(last_reg),
        "last delivered went backwards")

endmodule

// ===== src/riob_cmp.sv =====
// shared subtract and compare unit for sequence numbers
// depends on riob_pkg
module riob_cmp (
    input  logic [riob_pkg::CMP_W-1:0] a,
    input  logic [riob_pkg::CMP_W-1:0] b,
    output riob_pkg::cmp_res_t         res
);

    logic [riob_pkg::CMP_W:0] full;

    assign full     = {1'b0, a} - {1'b0, b};
    assign res.diff = full[riob_pkg::CMP_W-1:0];
    assign res.eq   = (full == '0);
    assign res.gt   = !full[riob_pkg::CMP_W] && (full != '0);

endmodule

// ===== src/riob_slot_store.sv =====
// slot store: sequence and handle memory with registered read, valid bits in flops
// depends on riob_pkg
module riob_slot_store #(
    parameter int WINDOW = 16,
    parameter int IDX_W  = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  logic [IDX_W-1:0]             wr_idx,
    input  logic [riob_pkg::SEQ_W-1:0]   wr_seq,
    input  logic [riob_pkg::HANDLE_W-1:0] wr_handle,
    input  logic                         clr_en,
    input  logic [IDX_W-1:0]             head,
    input  logic [IDX_W-1:0]             rd_addr,
    output logic                         head_valid,
    output logic [riob_pkg::SEQ_W-1:0]   rd_seq,
    output logic [riob_pkg::HANDLE_W-1:0] rd_handle
);

    logic [riob_pkg::SEQ_W-1:0]    seq_mem [WINDOW];
    logic [riob_pkg::HANDLE_W-1:0] handle_mem [WINDOW];
    logic [riob_pkg::SEQ_W-1:0]    rd_seq_reg;
    logic [riob_pkg::HANDLE_W-1:0] rd_handle_reg;
    logic [WINDOW-1:0]             valid_reg;
    logic [WINDOW-1:0]             valid_next;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            seq_mem[wr_idx]    <= wr_seq;
            handle_mem[wr_idx] <= wr_handle;
        end
        rd_seq_reg    <= seq_mem[rd_addr];
        rd_handle_reg <= handle_mem[rd_addr];
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (wr_en)
        begin
            valid_next[wr_idx] = 1'b1;
        end
        if (clr_en)
        begin
            valid_next[head] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign head_valid = valid_reg[head];
    assign rd_seq     = rd_seq_reg;
    assign rd_handle  = rd_handle_reg;

endmodule
